### rtl/bcoa_pkg.sv
// ----------------------------------------------------------------------------
// Block-cyclic owner assignment: shared definitions
// Widths, register indexes and the cycle-shape function of the block.
// ----------------------------------------------------------------------------
package bcoa_pkg;

	localparam int MAX_PROCS = 64;
	localparam int ID_BITS   = 24;
	localparam int PROC_W    = $clog2(MAX_PROCS);
	localparam int DIM_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int ROOT_MAX  = 8;
	localparam int SIDE_W    = $clog2(ROOT_MAX + 2);
	localparam int POS_W     = DIM_W + SIDE_W;
	localparam int DIV_CNT_W = $clog2(DIM_W);
	localparam int IN_W      = 4 * DIM_W + ID_BITS;
	localparam int OUT_RAW_W = 2 * ID_BITS + PROC_W;
	localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_PROCS    = 2'd0,
		REG_BLOCK_WIDTH  = 2'd1,
		REG_BLOCK_HEIGHT = 2'd2
	} cfg_reg_t;

	// Columns (nh) and rows (nv) of one block cycle for a process count.
	typedef struct packed {
		logic [SIDE_W-1:0] nh;
		logic [SIDE_W-1:0] nv;
	} cycle_shape_t;

	function automatic cycle_shape_t cycle_shape(input logic [PROC_W:0] p);
		logic [SIDE_W-1:0] root;
		cycle_shape_t      shape;
		root = '0;
		for (int i = 1; i <= ROOT_MAX; i++) begin
			if (i * i <= int'(p))
				root = SIDE_W'(i);
		end
		shape.nv = root;
		shape.nh = (int'(root) * int'(root) == int'(p)) ? root : SIDE_W'(root + 1'b1);
		return shape;
	endfunction

endpackage

### rtl/block_cyclic_owner_assign.sv
// ----------------------------------------------------------------------------
// Block-cyclic owner assignment
// Walks one block cycle of a subgrid and assigns each block to its process.
// ----------------------------------------------------------------------------
// Each input item names a subgrid and one block-cycle position. The block
// takes one item at a time. After an item is accepted, two 16-step restoring
// dividers work out the subgrid size in blocks, the ST_PREP and ST_RANGE setup
// steps find the part of the cycle that lies inside the subgrid, and then the
// slot walker visits one block slot per cycle, row by row, over the rows that
// fall inside, up to the last slot inside the subgrid; back pressure on the
// output stretches the walk. A cycle wholly outside the subgrid gives one
// flagged result. The walk rate is set by the per-process counter memory, a
// 64-entry synchronous RAM that is read for one slot per cycle and written back
// when that slot leaves the slot stage, with the last write forwarded. The
// counters are cleared at once by a row of valid bits, at reset and when an
// item carries restart, so no clearing pass is needed.
module block_cyclic_owner_assign (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [bcoa_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [bcoa_pkg::CFG_W-1:0]      cfg_data,
	// input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// subgrid_width, subgrid_height, first_block_id, cycle_x, cycle_y
	input  logic [bcoa_pkg::IN_W-1:0]       s_tdata,
	// restart
	input  logic                            s_tuser,
	// result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// global_block_id, owner_proc, local_block_id, zero padding
	output logic [bcoa_pkg::OUT_W-1:0]      m_tdata,
	// outside
	output logic                            m_tuser,
	output logic                            m_tlast
);
	import bcoa_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_RANGE = 6'b001000,
		ST_WALK  = 6'b010000,
		ST_FLAG  = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [PROC_W:0]  num_procs_q;
	logic [DIM_W-1:0] block_width_q;
	logic [DIM_W-1:0] block_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_procs_q    <= (PROC_W+1)'(1);
			block_width_q  <= DIM_W'(1);
			block_height_q <= DIM_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_NUM_PROCS:    num_procs_q    <= cfg_data[PROC_W:0];
				REG_BLOCK_WIDTH:  block_width_q  <= cfg_data[DIM_W-1:0];
				REG_BLOCK_HEIGHT: block_height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective process count and block sizes: zero acts as one, and the
	// process count saturates at the number of counters.
	logic [PROC_W:0]   p_eff;
	logic [PROC_W-1:0] last_owner;
	logic [DIM_W-1:0]  bw_eff;
	logic [DIM_W-1:0]  bh_eff;
	cycle_shape_t      shape;

	always_comb begin
		if (num_procs_q == '0)
			p_eff = (PROC_W+1)'(1);
		else if (num_procs_q > (PROC_W+1)'(MAX_PROCS))
			p_eff = (PROC_W+1)'(MAX_PROCS);
		else
			p_eff = num_procs_q;
		last_owner = PROC_W'(p_eff - 1'b1);
		bw_eff     = (block_width_q == '0) ? DIM_W'(1) : block_width_q;
		bh_eff     = (block_height_q == '0) ? DIM_W'(1) : block_height_q;
		shape      = cycle_shape(p_eff);
	end

	// Handshake.
	logic valid_s1;
	logic accept;
	assign s_tready = (state_q == ST_IDLE) && !valid_s1;
	assign accept   = s_tvalid && s_tready;

	// Latched item and the working registers of the setup steps.
	logic [DIM_W-1:0]     cx_q;
	logic [DIM_W-1:0]     cy_q;
	logic [ID_BITS-1:0]   first_q;
	logic [DIM_W-1:0]     num_x_q;
	logic [DIM_W-1:0]     num_y_q;
	logic [DIM_W-1:0]     rem_x_q;
	logic [DIM_W-1:0]     rem_y_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [DIM_W-1:0]     horiz_q;
	logic [DIM_W-1:0]     vert_q;
	logic [POS_W-1:0]     col0_q;
	logic [POS_W-1:0]     row0_q;
	logic                 zero_pos_q;
	logic [SIDE_W-1:0]    nin_c_q;
	logic [SIDE_W-1:0]    nin_r_q;
	logic [ID_BITS-1:0]   line_q;

	// Walker state.
	logic [SIDE_W-1:0]    bx_q;
	logic [SIDE_W-1:0]    by_q;
	logic [PROC_W-1:0]    owner_q;

	// One restoring division step for each of the two dividers.
	logic [DIM_W:0]   trial_x;
	logic [DIM_W:0]   trial_y;
	logic             qbit_x;
	logic             qbit_y;
	logic [DIM_W-1:0] rem_x_next;
	logic [DIM_W-1:0] rem_y_next;

	always_comb begin
		trial_x    = {rem_x_q, num_x_q[DIM_W-1]};
		trial_y    = {rem_y_q, num_y_q[DIM_W-1]};
		qbit_x     = trial_x >= {1'b0, bw_eff};
		qbit_y     = trial_y >= {1'b0, bh_eff};
		rem_x_next = qbit_x ? DIM_W'(trial_x - {1'b0, bw_eff}) : DIM_W'(trial_x);
		rem_y_next = qbit_y ? DIM_W'(trial_y - {1'b0, bh_eff}) : DIM_W'(trial_y);
	end

	// Part of the cycle inside the subgrid, and the id of the first row.
	logic [POS_W-1:0]       horiz_pos;
	logic [POS_W-1:0]       vert_pos;
	logic [POS_W-1:0]       col_room;
	logic [POS_W-1:0]       row_room;
	logic [SIDE_W-1:0]      nin_c;
	logic [SIDE_W-1:0]      nin_r;
	logic [DIM_W+POS_W-1:0] line_prod;
	logic                   outside_item;

	always_comb begin
		horiz_pos = POS_W'(horiz_q);
		vert_pos  = POS_W'(vert_q);
		col_room  = horiz_pos - col0_q;
		row_room  = vert_pos - row0_q;
		if (col0_q >= horiz_pos)
			nin_c = '0;
		else if (col_room > POS_W'(shape.nh))
			nin_c = shape.nh;
		else
			nin_c = col_room[SIDE_W-1:0];
		if (row0_q >= vert_pos)
			nin_r = '0;
		else if (row_room > POS_W'(shape.nv))
			nin_r = shape.nv;
		else
			nin_r = row_room[SIDE_W-1:0];
		line_prod    = (DIM_W+POS_W)'(horiz_q) * (DIM_W+POS_W)'(row0_q);
		outside_item = zero_pos_q || (nin_c == '0) || (nin_r == '0);
	end

	// Slot stage: holds one slot whose counter read is in flight.
	logic                 fire_s1;
	logic                 free_s1;
	logic                 issue;
	logic                 issue_flag;
	logic                 slot_inside;
	logic                 slot_last;
	logic                 row_end;
	logic [ID_BITS-1:0]   gid_s1;
	logic [PROC_W-1:0]    owner_s1;
	logic                 last_s1;
	logic                 outside_s1;
	logic [ID_BITS-1:0]   rd_s1;
	logic                 rdv_s1;

	assign fire_s1     = valid_s1 && (!m_tvalid || m_tready);
	assign free_s1     = !valid_s1 || fire_s1;
	assign slot_inside = bx_q < nin_c_q;
	assign slot_last   = (bx_q == SIDE_W'(nin_c_q - 1'b1)) && (by_q == SIDE_W'(nin_r_q - 1'b1));
	assign row_end     = bx_q == SIDE_W'(shape.nh - 1'b1);
	assign issue       = (state_q == ST_WALK) && free_s1 && slot_inside;
	assign issue_flag  = (state_q == ST_FLAG) && free_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == DIV_CNT_W'(DIM_W - 1))
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= ST_RANGE;
				end
				ST_RANGE: begin
					state_q <= outside_item ? ST_FLAG : ST_WALK;
				end
				ST_WALK: begin
					if (issue && slot_last)
						state_q <= ST_IDLE;
				end
				ST_FLAG: begin
					if (issue_flag)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Divider counter and walker counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			bx_q      <= '0;
			by_q      <= '0;
			owner_q   <= '0;
		end else begin
			if (accept)
				div_cnt_q <= '0;
			else if (state_q == ST_DIV)
				div_cnt_q <= div_cnt_q + 1'b1;

			if (state_q == ST_RANGE) begin
				bx_q    <= '0;
				by_q    <= '0;
				owner_q <= '0;
			end else if ((state_q == ST_WALK) && free_s1) begin
				// Slots outside the subgrid still take their owner turn.
				owner_q <= (owner_q == last_owner) ? '0 : owner_q + 1'b1;
				if (row_end) begin
					bx_q <= '0;
					by_q <= by_q + 1'b1;
				end else begin
					bx_q <= bx_q + 1'b1;
				end
			end
		end
	end

	// Item payload and setup datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			num_x_q <= s_tdata[DIM_W-1:0];
			num_y_q <= s_tdata[2*DIM_W-1:DIM_W];
			first_q <= s_tdata[2*DIM_W+ID_BITS-1:2*DIM_W];
			cx_q    <= s_tdata[3*DIM_W+ID_BITS-1:2*DIM_W+ID_BITS];
			cy_q    <= s_tdata[4*DIM_W+ID_BITS-1:3*DIM_W+ID_BITS];
			rem_x_q <= '0;
			rem_y_q <= '0;
		end else if (state_q == ST_DIV) begin
			num_x_q <= {num_x_q[DIM_W-2:0], qbit_x};
			num_y_q <= {num_y_q[DIM_W-2:0], qbit_y};
			rem_x_q <= rem_x_next;
			rem_y_q <= rem_y_next;
		end

		if (state_q == ST_PREP) begin
			// Quotients round up to whole blocks.
			horiz_q    <= DIM_W'({1'b0, num_x_q} + (DIM_W+1)'(rem_x_q != '0));
			vert_q     <= DIM_W'({1'b0, num_y_q} + (DIM_W+1)'(rem_y_q != '0));
			col0_q     <= POS_W'((POS_W'(cx_q) - 1'b1) * POS_W'(shape.nh));
			row0_q     <= POS_W'((POS_W'(cy_q) - 1'b1) * POS_W'(shape.nv));
			zero_pos_q <= (cx_q == '0) || (cy_q == '0);
		end

		if (state_q == ST_RANGE) begin
			nin_c_q <= nin_c;
			nin_r_q <= nin_r;
			line_q  <= first_q + ID_BITS'(line_prod);
		end else if ((state_q == ST_WALK) && free_s1 && row_end) begin
			line_q <= line_q + ID_BITS'(horiz_q);
		end
	end

	// Per-process counter memory with valid bits and last-write forwarding.
	logic [ID_BITS-1:0] cnt_mem [MAX_PROCS];
	logic [MAX_PROCS-1:0] vld_q;
	logic               wr_en;
	logic [ID_BITS-1:0] cnt_base;
	logic [ID_BITS-1:0] cnt_new;
	logic               fwd_v_q;
	logic [PROC_W-1:0]  fwd_owner_q;
	logic [ID_BITS-1:0] fwd_cnt_q;

	assign wr_en = fire_s1 && !outside_s1;

	always_comb begin
		if (fwd_v_q && (fwd_owner_q == owner_s1))
			cnt_base = fwd_cnt_q;
		else if (rdv_s1)
			cnt_base = rd_s1;
		else
			cnt_base = '0;
		cnt_new = cnt_base + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (issue)
			rd_s1 <= cnt_mem[owner_q];
		if (wr_en)
			cnt_mem[owner_s1] <= cnt_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			fwd_v_q <= 1'b0;
		end else if (accept && s_tuser) begin
			vld_q   <= '0;
			fwd_v_q <= 1'b0;
		end else if (wr_en) begin
			vld_q[owner_s1] <= 1'b1;
			fwd_v_q         <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_owner_q <= owner_s1;
			fwd_cnt_q   <= cnt_new;
		end
	end

	// Slot stage control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (issue || issue_flag)
			valid_s1 <= 1'b1;
		else if (fire_s1)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			gid_s1     <= line_q + ID_BITS'(col0_q) + ID_BITS'(bx_q);
			owner_s1   <= owner_q;
			last_s1    <= slot_last;
			outside_s1 <= 1'b0;
			rdv_s1     <= vld_q[owner_q];
		end else if (issue_flag) begin
			gid_s1     <= '0;
			owner_s1   <= '0;
			last_s1    <= 1'b1;
			outside_s1 <= 1'b1;
			rdv_s1     <= 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (fire_s1)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			m_tdata <= OUT_W'({(outside_s1 ? ID_BITS'(0) : cnt_new), owner_s1, gid_s1});
			m_tuser <= outside_s1;
			m_tlast <= last_s1;
		end
	end

`ifndef SYNTH
	// The slot stage is drained before a new item's division starts.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> !valid_s1)
		else $error("slot stage busy during division");

	// A restart leaves every counter reading as zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser) |=> (vld_q == '0) && !fwd_v_q)
		else $error("counters not cleared on restart");

	// A flagged result is the single, all-zero result of its item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
		else $error("malformed outside result");
`endif

endmodule

### test/owner_assign_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block-cyclic owner assignment: result checker
// Follows the configuration writes and the accepted input items, works out the
// block placements each item should give, and compares every result with them.
// ----------------------------------------------------------------------------
module owner_assign_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bcoa_pkg::CFG_IDX_W-1:0] cfg_addr,
	input  logic [bcoa_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [bcoa_pkg::IN_W-1:0]      s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [bcoa_pkg::OUT_W-1:0]     m_tdata,
	input  logic                           m_tuser,
	input  logic                           m_tlast,
	output int                             errors,
	output int                             pending
);
	import bcoa_pkg::*;

	typedef struct packed {
		logic [ID_BITS-1:0] global_id;
		logic [PROC_W-1:0]  owner;
		logic [ID_BITS-1:0] owner_seq;
		logic               outside;
		logic               tail;
	} placement_t;

	placement_t         placements_q[$];
	logic [6:0]         procs_cfg;
	logic [DIM_W-1:0]   bw_cfg;
	logic [DIM_W-1:0]   bh_cfg;
	logic [ID_BITS-1:0] owned_blocks [MAX_PROCS];
	int                 results_seen;

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t: result %0d: %s", $time, results_seen, msg);
	endtask

	// Walks one block cycle and queues the placements it should produce.
	task automatic place_cycle(input logic [IN_W-1:0] item, input logic restart);
		logic [DIM_W-1:0]   sw, sh, cx, cy;
		logic [ID_BITS-1:0] first_id;
		int unsigned        p, root, nh, nv, bw, bh, horiz, vert;
		int unsigned        slot, col, row, bx, by;
		longint unsigned    gid;
		logic [PROC_W-1:0]  owner;
		placement_t         held;
		bit                 have_held;
		{cy, cx, first_id, sh, sw} = item;
		if (restart) begin
			foreach (owned_blocks[i])
				owned_blocks[i] = '0;
		end
		p = procs_cfg;
		if (p == 0)
			p = 1;
		if (p > MAX_PROCS)
			p = MAX_PROCS;
		root = 0;
		while ((root + 1) * (root + 1) <= p)
			root++;
		nv = root;
		nh = (root * root == p) ? root : root + 1;
		bw = (bw_cfg == 0) ? 1 : bw_cfg;
		bh = (bh_cfg == 0) ? 1 : bh_cfg;
		horiz = (sw + bw - 1) / bw;
		vert = (sh + bh - 1) / bh;
		slot = 0;
		have_held = 0;
		held = '0;
		if (cx != 0 && cy != 0) begin
			for (by = 0; by < nv; by++) begin
				for (bx = 0; bx < nh; bx++) begin
					col = (cx - 1) * nh + bx;
					row = (cy - 1) * nv + by;
					owner = PROC_W'(slot % p);
					slot++;
					if (col < horiz && row < vert) begin
						if (have_held)
							placements_q = {placements_q, held};
						owned_blocks[owner] = owned_blocks[owner] + 1'b1;
						gid = longint'(first_id) + longint'(horiz) * row + col;
						held = '0;
						held.global_id = ID_BITS'(gid);
						held.owner = owner;
						held.owner_seq = owned_blocks[owner];
						have_held = 1;
					end
				end
			end
		end
		// A cycle with nothing inside gives a single flagged result.
		if (!have_held)
			held.outside = 1'b1;
		held.tail = 1'b1;
		placements_q = {placements_q, held};
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		placement_t got;
		placement_t want;
		if (!arst_n) begin
			procs_cfg = 7'd1;
			bw_cfg = 16'd1;
			bh_cfg = 16'd1;
			foreach (owned_blocks[i])
				owned_blocks[i] = '0;
			placements_q.delete();
			errors = 0;
			results_seen = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_NUM_PROCS:    procs_cfg = cfg_data[6:0];
					REG_BLOCK_WIDTH:  bw_cfg = cfg_data;
					REG_BLOCK_HEIGHT: bh_cfg = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				place_cycle(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				got.global_id = m_tdata[ID_BITS-1:0];
				got.owner = m_tdata[ID_BITS +: PROC_W];
				got.owner_seq = m_tdata[ID_BITS+PROC_W +: ID_BITS];
				got.outside = m_tuser;
				got.tail = m_tlast;
				if (placements_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result gid %h owner %0d",
						got.global_id, got.owner));
				end else begin
					want = placements_q.pop_front();
					if (got.global_id !== want.global_id)
						report_mismatch($sformatf("global_block_id %h, expected %h",
							got.global_id, want.global_id));
					if (got.owner !== want.owner)
						report_mismatch($sformatf("owner_proc %0d, expected %0d",
							got.owner, want.owner));
					if (got.owner_seq !== want.owner_seq)
						report_mismatch($sformatf("local_block_id %h, expected %h",
							got.owner_seq, want.owner_seq));
					if (got.outside !== want.outside)
						report_mismatch($sformatf("outside %b, expected %b",
							got.outside, want.outside));
					if (got.tail !== want.tail)
						report_mismatch($sformatf("last %b, expected %b",
							got.tail, want.tail));
				end
				results_seen++;
			end
		end
		pending <= placements_q.size();
	end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block-cyclic owner assignment: testbench top
// Drives configuration phases and block-cycle items into the block, with random
// idling on both streams, and reports the checker's verdict at the end.
// ----------------------------------------------------------------------------
module tb_top;
	import bcoa_pkg::*;

	// Longest stretch without any accepted item, result or register write
	// before the run is given up.
	localparam int WATCHDOG_LIMIT = 2000;
	// Cycles allowed after the last result for the slot walker to drain
	// its counter write-back before a register is changed.
	localparam int DRAIN_CYCLES   = 8;
	localparam int SETTLE_CYCLES  = 100;
	localparam int PHASES         = 8;
	localparam int PHASE_ITEMS    = 40;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	int                   mismatches;
	int                   pending;

	// Idling controls. In the calm part at the end nobody idles.
	bit                   calm = 1'b0;
	int unsigned          gap_pct = 20;
	int unsigned          stall_pct = 10;

	// Effective settings as the stimulus sees them, used only to aim the
	// cycle positions at the interesting part of each subgrid.
	logic [PROC_W:0]      procs_now = 7'd1;
	int unsigned          bw_now = 1;
	int unsigned          bh_now = 1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	block_cyclic_owner_assign u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	owner_assign_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.errors   (mismatches),
		.pending  (pending)
	);

	// Result-side back pressure: random stall bursts, each ending with ready raised
	// again before the next burst can start, so that stalls land on every point of the walk.
	always begin
		@(posedge clk);
		if (!calm && $urandom_range(0, 99) < stall_pct) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		m_tready <= 1'b1;
	end

	// The watchdog restarts its count on any accepted item or result or on any register write.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Offers one block-cycle item, possibly after a gap, and returns at the
	// edge where it is accepted. tvalid stays high into the next item unless
	// that item starts with a gap.
	task automatic send_item(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
			input logic [ID_BITS-1:0] first_id, input logic [DIM_W-1:0] cx,
			input logic [DIM_W-1:0] cy, input logic restart);
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {cy, cx, first_id, sh, sw};
		s_tuser <= restart;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Holds the input back until every expected result has come out, then
	// lets the block settle for the given number of cycles.
	task automatic wait_idle(input int settle);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Writes all three registers while the block is idle. The process count
	// is passed as the full write word, so bits above the register width can
	// be exercised too.
	task automatic write_config(input logic [CFG_W-1:0] procs_word,
			input logic [CFG_W-1:0] bw, input logic [CFG_W-1:0] bh);
		wait_idle(DRAIN_CYCLES);
		cfg_we <= 1'b1;
		cfg_addr <= REG_NUM_PROCS;
		cfg_data <= procs_word;
		@(posedge clk);
		cfg_addr <= REG_BLOCK_WIDTH;
		cfg_data <= bw;
		@(posedge clk);
		cfg_addr <= REG_BLOCK_HEIGHT;
		cfg_data <= bh;
		@(posedge clk);
		cfg_we <= 1'b0;
		procs_now = procs_word[6:0];
		if (procs_now == 0)
			procs_now = (PROC_W+1)'(1);
		if (procs_now > MAX_PROCS)
			procs_now = (PROC_W+1)'(MAX_PROCS);
		bw_now = (bw == 0) ? 1 : bw;
		bh_now = (bh == 0) ? 1 : bh;
	endtask

	// Subgrid sizes: half the time at most 12 blocks, so that cycles get clipped at the
	// edges, with full-range and largest sizes mixed in.
	function automatic logic [DIM_W-1:0] pick_size(input int unsigned blk);
		longint unsigned span;
		case ($urandom_range(0, 3))
			0: span = $urandom_range(1, 16'hFFFF);
			1: span = longint'(blk) * $urandom_range(1, 12);
			2: span = $urandom_range(1, blk * 12 > 16'hFFFF ? 16'hFFFF : blk * 12);
			default: span = 16'hFFFF;
		endcase
		if (span > 16'hFFFF)
			span = 16'hFFFF;
		return DIM_W'(span);
	endfunction

	// One random item. Most items name a cycle that lies at least partly in
	// the subgrid, a third of those at its far edge; the rest are noise or
	// cycles just past the edge.
	task automatic random_item();
		cycle_shape_t     shape;
		logic [DIM_W-1:0] sw, sh, cx, cy;
		int unsigned      horiz, vert, span_x, span_y, kind;
		shape = cycle_shape(procs_now);
		sw = pick_size(bw_now);
		sh = pick_size(bh_now);
		horiz = (sw + bw_now - 1) / bw_now;
		vert = (sh + bh_now - 1) / bh_now;
		span_x = (horiz + shape.nh - 1) / shape.nh;
		span_y = (vert + shape.nv - 1) / shape.nv;
		kind = $urandom_range(0, 9);
		if (kind < 8) begin
			cx = DIM_W'(($urandom_range(0, 2) == 0) ? span_x : $urandom_range(1, span_x));
			cy = DIM_W'(($urandom_range(0, 2) == 0) ? span_y : $urandom_range(1, span_y));
		end else if (kind == 8) begin
			sw = DIM_W'($urandom_range(0, 16'hFFFF));
			sh = DIM_W'($urandom_range(0, 16'hFFFF));
			cx = DIM_W'($urandom_range(0, 16'hFFFF));
			cy = DIM_W'($urandom_range(0, 16'hFFFF));
		end else begin
			cx = ($urandom_range(0, 1) == 0) ? DIM_W'(span_x + 1) :
				DIM_W'($urandom_range(1, span_x));
			cy = (cx > span_x) ? DIM_W'($urandom_range(1, span_y)) : DIM_W'(span_y + 1);
		end
		send_item(sw, sh, ID_BITS'($urandom_range(0, 24'hFFFFFF)), cx, cy,
			$urandom_range(0, 9) == 0);
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] procs_word, bw, bh;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset settings: one process, unit blocks.
		send_item(16'd1, 16'd1, 24'd1, 16'd1, 16'd1, 1'b0);
		// The second block, one past the top id, wraps the global id to zero.
		send_item(16'd2, 16'd1, 24'hFFFFFF, 16'd2, 16'd1, 1'b0);
		// Largest subgrid and the very last cycle position inside it.
		send_item(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		// A zero cycle position on either axis counts as wholly outside.
		send_item(16'd5, 16'd5, 24'd10, 16'd0, 16'd1, 1'b0);
		send_item(16'd5, 16'd5, 24'd10, 16'd1, 16'd0, 1'b0);
		// A subgrid with no width or no height holds no block at all.
		send_item(16'd0, 16'd5, 24'd10, 16'd1, 16'd1, 1'b0);
		send_item(16'd5, 16'd0, 24'd10, 16'd1, 16'd1, 1'b0);
		// A cycle past the right edge, then a restart of the counters.
		send_item(16'd5, 16'd5, 24'd10, 16'd6, 16'd1, 1'b0);
		send_item(16'd5, 16'd5, 24'd10, 16'd3, 16'd3, 1'b1);

		// Zero process count and zero block sizes behave as one.
		write_config(16'd0, 16'd0, 16'd0);
		send_item(16'd3, 16'd3, 24'd100, 16'd2, 16'd2, 1'b0);
		send_item(16'd3, 16'd3, 24'd100, 16'd3, 16'd3, 1'b0);

		// All 64 processes, written with the upper data bits set: a full
		// cycle with 8 blocks on each side, one clipped at both edges, and another full one.
		write_config(16'hFFC0, 16'd1, 16'd1);
		send_item(16'hFFFF, 16'hFFFF, 24'd1, 16'd1, 16'd1, 1'b1);
		send_item(16'd12, 16'd10, 24'd500, 16'd2, 16'd2, 1'b0);
		send_item(16'd8, 16'd8, 24'd7, 16'd1, 16'd1, 1'b0);

		// Process count above the maximum, largest block sizes.
		write_config(16'd127, 16'hFFFF, 16'hFFFF);
		send_item(16'hFFFF, 16'hFFFF, 24'hABCDEF, 16'd1, 16'd1, 1'b0);
		send_item(16'hFFFF, 16'd1, 24'd5, 16'd1, 16'd2, 1'b0);

		// Three processes give a two by one cycle.
		write_config(16'd3, 16'd7, 16'd3);
		send_item(16'd20, 16'd9, 24'd40, 16'd2, 16'd3, 1'b0);
		send_item(16'd20, 16'd9, 24'd40, 16'd2, 16'd1, 1'b1);

		// Random phases, each with its own settings and idling mix. The
		// last phase runs without any idling.
		for (int phase = 0; phase < PHASES; phase++) begin
			case ($urandom_range(0, 7))
				0: procs_word = 16'd0;
				1: procs_word = CFG_W'($urandom_range(65, 127));
				2: procs_word = 16'd64;
				3: procs_word = 16'd1;
				default: procs_word = CFG_W'($urandom_range(2, 63));
			endcase
			procs_word[CFG_W-1:7] = 9'($urandom_range(0, 511));
			case ($urandom_range(0, 5))
				0: bw = 16'd0;
				1: bw = 16'hFFFF;
				2: bw = CFG_W'($urandom_range(1, 16'hFFFF));
				default: bw = CFG_W'($urandom_range(1, 64));
			endcase
			case ($urandom_range(0, 5))
				0: bh = 16'd0;
				1: bh = 16'hFFFF;
				2: bh = CFG_W'($urandom_range(1, 16'hFFFF));
				default: bh = CFG_W'($urandom_range(1, 64));
			endcase
			write_config(procs_word, bw, bh);
			case ($urandom_range(0, 2))
				0: gap_pct = 0;
				1: gap_pct = 15;
				default: gap_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 10;
				default: stall_pct = 30;
			endcase
			calm = (phase == PHASES - 1);
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_item();
		end

		wait_idle(SETTLE_CYCLES);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
